@@ src/particle_force_euler_step_2d_core_assert.svh @@
// Assertion macros used by the checker file.
`ifndef PARTICLE_FORCE_EULER_STEP_2D_CORE_ASSERT_SVH
`define PARTICLE_FORCE_EULER_STEP_2D_CORE_ASSERT_SVH
// Assert that an antecedent implies a consequent in the next cycle.
`define PFE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
// Assert that a condition holds on every cycle out of reset.
`define PFE_ASSERT_ALWAYS(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("assertion failed");
`endif

@@ src/pfe_pkg.sv @@
// ----------------------------------------------------------------------------
// pfe_pkg
// Types and constants for the 2D particle Euler step core.
// ----------------------------------------------------------------------------
package pfe_pkg;

    localparam int unsigned W = 32;
    localparam int unsigned F = 16;

    localparam logic [2:0] ACT_FORCE     = 3'd0;
    localparam logic [2:0] ACT_ATTRACT   = 3'd1;
    localparam logic [2:0] ACT_REPEL     = 3'd2;
    localparam logic [2:0] ACT_INTEGRATE = 3'd3;
    localparam logic [2:0] ACT_BOUNCE    = 3'd4;
    localparam logic [2:0] ACT_WRAP      = 3'd5;

    localparam logic [2:0] CFG_FRICTION = 3'd0;
    localparam logic [2:0] CFG_INV_MASS = 3'd1;
    localparam logic [2:0] CFG_XMIN     = 3'd2;
    localparam logic [2:0] CFG_YMIN     = 3'd3;
    localparam logic [2:0] CFG_XMAX     = 3'd4;
    localparam logic [2:0] CFG_YMAX     = 3'd5;

    typedef struct packed {
        logic [2:0]         action;
        logic signed [31:0] force_x;
        logic signed [31:0] force_y;
        logic signed [31:0] point_x;
        logic signed [31:0] point_y;
        logic signed [31:0] reach;
        logic signed [31:0] strength;
    } t_in;

    typedef struct packed {
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] vel_x;
        logic signed [31:0] vel_y;
    } t_out;

    // Shared divider/sqrt unit request and status.
    typedef struct packed {
        logic        start;
        logic        is_sqrt;
        logic [63:0] num;   // dividend magnitude or radicand
        logic [31:0] den;   // divisor magnitude
    } t_du_req;

    typedef struct packed {
        logic        busy;
        logic        done;
        logic [63:0] res;
    } t_du_rsp;

    typedef enum logic [4:0] {
        S_IDLE, S_FMUL, S_DIFF, S_SQ, S_SQRT, S_SQRTW, S_CHK, S_PCTD, S_PCTW,
        S_UXD, S_UXW, S_TXM1, S_TXM2, S_UYD, S_UYW, S_TYM1, S_TYM2, S_ACC,
        S_FRIC, S_VEL, S_POS, S_BX, S_BY, S_WRAP, S_OUT
    } t_state;

    function automatic logic signed [31:0] sat64(input logic signed [63:0] v);
        if (v > 64'sd2147483647)       return 32'sh7fffffff;
        else if (v < -64'sd2147483648) return 32'sh80000000;
        else                           return v[31:0];
    endfunction

endpackage

@@ src/pfe_divsqrt.sv @@
// ----------------------------------------------------------------------------
// pfe_divsqrt
// Shared bit-serial unit: unsigned 64/32 division or 64-bit integer sqrt.
// ----------------------------------------------------------------------------
module pfe_divsqrt (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  pfe_pkg::t_du_req i_req,
    output pfe_pkg::t_du_rsp o_rsp
);
    import pfe_pkg::*;

    logic [63:0] r_n, n_n;      // remaining radicand / dividend shift
    logic [63:0] r_q, n_q;      // quotient or root
    logic [63:0] r_rem, n_rem;
    logic [63:0] r_b, n_b;      // sqrt bit
    logic [31:0] r_d;
    logic [6:0]  r_cnt, n_cnt;
    logic        r_busy, r_done, r_sq;
    logic [64:0] w_trial;

    always_comb begin
        n_n = r_n; n_q = r_q; n_rem = r_rem; n_b = r_b; n_cnt = r_cnt;
        w_trial = '0;
        if (r_sq) begin
            // one root bit per cycle
            if (r_n >= r_q + r_b) begin
                n_n = r_n - (r_q + r_b);
                n_q = (r_q >> 1) + r_b;
            end else begin
                n_q = r_q >> 1;
            end
            n_b = r_b >> 2;
        end else begin
            // one quotient bit per cycle, restoring
            w_trial = {r_rem, r_n[63]};
            n_n = {r_n[62:0], 1'b0};
            if (w_trial >= {33'd0, r_d}) begin
                n_rem = 64'(w_trial - {33'd0, r_d});
                n_q = {r_q[62:0], 1'b1};
            end else begin
                n_rem = w_trial[63:0];
                n_q = {r_q[62:0], 1'b0};
            end
        end
        n_cnt = r_cnt - 7'd1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_sq   <= i_req.is_sqrt;
                r_n    <= i_req.num;
                r_q    <= '0;
                r_rem  <= '0;
                r_d    <= i_req.den;
                r_b    <= 64'h4000_0000_0000_0000;
                r_cnt  <= i_req.is_sqrt ? 7'd32 : 7'd64;
            end else if (r_busy) begin
                r_n <= n_n; r_q <= n_q; r_rem <= n_rem; r_b <= n_b; r_cnt <= n_cnt;
                if (r_cnt == 7'd1) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_rsp.busy = r_busy;
    assign o_rsp.done = r_done;
    assign o_rsp.res  = r_q;
endmodule

@@ src/particle_force_euler_step_2d_core.sv @@
// ----------------------------------------------------------------------------
// particle_force_euler_step_2d_core
// One 2D Q16.16 particle: forces, point attract/repel, Euler step, walls.
// ----------------------------------------------------------------------------
// channel | dir | handshake         | payload
// in      | in  | i_valid / o_ready | i_in  (t_in)
// out     | out | o_valid / i_ready | o_out (t_out)
// cfg     | in  | i_cfg_we          | i_cfg_idx, i_cfg_data
//
// Attract/repel run a sqrt and up to three divisions on the shared divsqrt
// unit, skipping the divisions when out of reach; spare codes go straight
// to output. No new beat is taken until the result beat has been loaded.
// Reset clears state to the center of the default bounds with zero motion.
// A stalled result beat holds the core in its output state until taken.
module particle_force_euler_step_2d_core (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  pfe_pkg::t_in  i_in,
    output logic          o_valid,
    input  logic          i_ready,
    output pfe_pkg::t_out o_out,
    input  logic          i_cfg_we,
    input  logic [2:0]    i_cfg_idx,
    input  logic [31:0]   i_cfg_data
);
    import pfe_pkg::*;

    // configuration
    logic [16:0]        r_fric;
    logic [30:0]        r_imass;
    logic signed [31:0] r_xmin, r_ymin, r_xmax, r_ymax;

    // particle state
    logic signed [31:0] r_px, r_py, r_vx, r_vy, r_ax, r_ay;

    // working registers
    t_state             r_st, n_st;
    t_in                r_cmd;
    logic signed [31:0] r_dx, r_dy, r_pct;
    logic [31:0]        r_dist;    // root can pass the signed word range
    logic signed [32:0] r_tx;      // x term, one bit wider than a word
    logic signed [63:0] r_acc;     // registered product / quotient
    logic               r_valid;
    t_out               r_out;

    t_du_req            w_req;
    t_du_rsp            w_rsp;

    // single shared multiplier, one product per cycle
    logic signed [33:0] w_ma, w_mb;
    logic signed [67:0] w_prod;
    assign w_prod = w_ma * w_mb;

    pfe_divsqrt u_du (.i_clk(i_clk), .i_rst_n(i_rst_n), .i_req(w_req), .o_rsp(w_rsp));

    // signed quotient of a signed numerator over positive dist
    logic signed [63:0] w_quot;
    logic               r_neg;
    assign w_quot = r_neg ? -$signed(w_rsp.res) : $signed(w_rsp.res);

    // next state
    always_comb begin
        n_st = r_st;
        unique case (r_st)
            S_IDLE:  if (i_valid) begin
                unique case (i_in.action)
                    ACT_FORCE:               n_st = S_FMUL;
                    ACT_ATTRACT, ACT_REPEL:  n_st = S_DIFF;
                    ACT_INTEGRATE:           n_st = S_FRIC;
                    ACT_BOUNCE:              n_st = S_BX;
                    ACT_WRAP:                n_st = S_WRAP;
                    default:                 n_st = S_OUT;
                endcase
            end
            S_FMUL:  n_st = S_ACC;
            S_DIFF:  n_st = S_SQ;
            S_SQ:    n_st = S_SQRT;
            S_SQRT:  n_st = S_SQRTW;
            S_SQRTW: if (w_rsp.done) n_st = S_CHK;
            S_CHK: begin
                if ((r_cmd.reach > 0 && r_dist > r_cmd.reach) || r_dist == 0) n_st = S_OUT;
                else if (r_cmd.reach > 0) n_st = S_PCTD;
                else n_st = S_UXD;
            end
            S_PCTD:  n_st = S_PCTW;
            S_PCTW:  if (w_rsp.done) n_st = S_UXD;
            S_UXD:   n_st = S_UXW;
            S_UXW:   if (w_rsp.done) n_st = S_TXM1;
            S_TXM1:  n_st = S_TXM2;
            S_TXM2:  n_st = S_UYD;
            S_UYD:   n_st = S_UYW;
            S_UYW:   if (w_rsp.done) n_st = S_TYM1;
            S_TYM1:  n_st = S_TYM2;
            S_TYM2:  n_st = S_ACC;
            S_ACC:   n_st = S_OUT;
            S_FRIC:  n_st = S_VEL;
            S_VEL:   n_st = S_POS;
            S_POS:   n_st = S_OUT;
            S_BX:    n_st = S_BY;
            S_BY:    n_st = S_OUT;
            S_WRAP:  n_st = S_OUT;
            S_OUT:   if (!r_valid || i_ready) n_st = S_IDLE;
            default: n_st = S_IDLE;
        endcase
    end

    // datapath controls
    always_comb begin
        w_req = '0;
        w_ma = '0;
        w_mb = '0;
        unique case (r_st)
            S_FMUL: begin w_ma = 34'(r_cmd.force_x); w_mb = {3'b0, r_imass}; end
            S_SQ:   begin w_ma = 34'(r_dx); w_mb = 34'(r_dx); end
            S_SQRT: begin
                w_ma = 34'(r_dy); w_mb = 34'(r_dy);
                w_req.start = 1'b1; w_req.is_sqrt = 1'b1;
                w_req.num = r_acc + w_prod[63:0];
            end
            S_PCTD: begin
                w_req.start = 1'b1;
                w_req.num = {16'd0, r_dist, 16'd0};
                w_req.den = r_cmd.reach;
            end
            S_UXD: begin
                w_req.start = 1'b1;
                w_req.num = {16'd0, (r_dx < 0) ? 32'(-33'(r_dx)) : 32'(r_dx), 16'd0};
                w_req.den = r_dist;
            end
            S_UYD: begin
                w_req.start = 1'b1;
                w_req.num = {16'd0, (r_dy < 0) ? 32'(-33'(r_dy)) : 32'(r_dy), 16'd0};
                w_req.den = r_dist;
            end
            S_TXM1, S_TYM1: begin w_ma = r_acc[33:0]; w_mb = 34'(r_cmd.strength); end
            S_TXM2, S_TYM2: begin w_ma = r_acc[33:0]; w_mb = 34'(r_pct); end
            S_ACC: if (r_cmd.action == ACT_FORCE) begin
                // y force product on the same multiplier
                w_ma = 34'(r_cmd.force_y); w_mb = {3'b0, r_imass};
            end
            S_FRIC: begin w_ma = 34'(r_vx); w_mb = {17'd0, r_fric}; end
            S_VEL:  begin w_ma = 34'(r_vy); w_mb = {17'd0, r_fric}; end
            default: ;
        endcase
    end

    assign o_ready = (r_st == S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st    <= S_IDLE;
            r_valid <= 1'b0;
            r_fric  <= 17'd655;
            r_imass <= 31'd65536;
            r_xmin  <= 32'sd0;
            r_ymin  <= 32'sd0;
            r_xmax  <= 32'sd67108864;
            r_ymax  <= 32'sd50331648;
            r_px    <= 32'sd33554432;
            r_py    <= 32'sd25165824;
            r_vx    <= '0; r_vy <= '0; r_ax <= '0; r_ay <= '0;
        end else begin
            r_st <= n_st;
            // load a fresh result beat, or drop the taken one
            if (r_st == S_OUT && (!r_valid || i_ready)) r_valid <= 1'b1;
            else if (r_valid && i_ready) r_valid <= 1'b0;
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_FRICTION: r_fric  <= i_cfg_data[16:0];
                    CFG_INV_MASS: r_imass <= i_cfg_data[30:0];
                    CFG_XMIN:     r_xmin  <= i_cfg_data;
                    CFG_YMIN:     r_ymin  <= i_cfg_data;
                    CFG_XMAX:     r_xmax  <= i_cfg_data;
                    CFG_YMAX:     r_ymax  <= i_cfg_data;
                    default: ;
                endcase
            end
            unique case (r_st)
                S_IDLE: if (i_valid) r_cmd <= i_in;
                S_FMUL: begin
                    // y product folds into the accumulate stage below
                    r_ax <= sat64(64'(r_ax) + 64'(sat64($signed(w_prod[63:0]) >>> 16)));
                end
                S_DIFF: begin
                    r_dx <= sat64(64'(r_px) - 64'(r_cmd.point_x));
                    r_dy <= sat64(64'(r_py) - 64'(r_cmd.point_y));
                end
                S_SQ:    r_acc <= w_prod[63:0];
                S_SQRTW: if (w_rsp.done) r_dist <= w_rsp.res[31:0];
                S_CHK:   r_pct <= 32'sd65536;
                S_PCTW:  if (w_rsp.done) r_pct <= 32'sd65536 - w_rsp.res[31:0];
                S_UXD:   r_neg <= r_dx < 0;
                S_UYD:   r_neg <= r_dy < 0;
                S_UXW, S_UYW: if (w_rsp.done) r_acc <= w_quot;
                S_TXM1, S_TYM1: r_acc <= $signed(w_prod[63:0]) >>> 16;
                S_TXM2: r_tx <= 33'($signed(w_prod[63:0]) >>> 16);
                S_TYM2: r_acc <= $signed(w_prod[63:0]) >>> 16;
                S_ACC: begin
                    if (r_cmd.action == ACT_FORCE) begin
                        r_ay <= sat64(64'(r_ay) +
                                      64'(sat64($signed(w_prod[63:0]) >>> 16)));
                    end else if (r_cmd.action == ACT_REPEL) begin
                        r_ax <= sat64(64'(r_ax) + 64'(r_tx));
                        r_ay <= sat64(64'(r_ay) + r_acc);
                    end else begin
                        r_ax <= sat64(64'(r_ax) - 64'(r_tx));
                        r_ay <= sat64(64'(r_ay) - r_acc);
                    end
                end
                S_FRIC: r_ax <= sat64(64'(r_ax) - ($signed(w_prod[63:0]) >>> 16));
                S_VEL: begin
                    r_ay <= '0;
                    r_ax <= '0;
                    r_vx <= sat64(64'(r_vx) + 64'(r_ax));
                    r_vy <= sat64(64'(r_vy) +
                                  64'(sat64(64'(r_ay) - ($signed(w_prod[63:0]) >>> 16))));
                end
                S_POS: begin
                    r_px <= sat64(64'(r_px) + 64'(r_vx));
                    r_py <= sat64(64'(r_py) + 64'(r_vy));
                end
                S_BX: begin
                    // crossed walls: above max lands on min, velocity negated twice
                    if (r_px > r_xmax) begin
                        r_px <= (r_xmax < r_xmin) ? r_xmin : r_xmax;
                        r_vx <= (r_xmax < r_xmin) ? sat64(-64'(sat64(-64'(r_vx))))
                                                  : sat64(-64'(r_vx));
                    end else if (r_px < r_xmin) begin
                        r_px <= r_xmin;
                        r_vx <= sat64(-64'(r_vx));
                    end
                    if (r_py > r_ymax) begin
                        r_py <= (r_ymax < r_ymin) ? r_ymin : r_ymax;
                        r_vy <= (r_ymax < r_ymin) ? sat64(-64'(sat64(-64'(r_vy))))
                                                  : sat64(-64'(r_vy));
                    end else if (r_py < r_ymin) begin
                        r_py <= r_ymin;
                        r_vy <= sat64(-64'(r_vy));
                    end
                end
                S_BY: ;
                S_WRAP: begin
                    if (r_px < r_xmin) r_px <= r_xmax;
                    else if (r_px > r_xmax) r_px <= r_xmin;
                    if (r_py < r_ymin) r_py <= r_ymax;
                    else if (r_py > r_ymax) r_py <= r_ymin;
                end
                S_OUT: if (!r_valid || i_ready) begin
                    r_out.pos_x <= r_px;
                    r_out.pos_y <= r_py;
                    r_out.vel_x <= r_vx;
                    r_out.vel_y <= r_vy;
                end
                default: ;
            endcase
        end
    end

    assign o_valid = r_valid;
    assign o_out   = r_out;
endmodule

@@ src/pfe_checker.sv @@
// ----------------------------------------------------------------------------
// pfe_checker
// Port-level checks on the particle core, bound into the core module.
// ----------------------------------------------------------------------------
`include "particle_force_euler_step_2d_core_assert.svh"
module pfe_checker (
    input logic         i_clk,
    input logic         i_rst_n,
    input logic         i_valid,
    input logic         o_ready,
    input logic         o_valid,
    input logic         i_ready,
    input pfe_pkg::t_out o_out
);
    // Drop ready for the beat after an accepted input.
    `PFE_ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, i_valid && o_ready, !o_ready)
    // Hold the result while stalled.
    `PFE_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_valid && !i_ready, o_valid && $stable(o_out))
    // A fresh result appears only while the core is busy.
    `PFE_ASSERT_NEXT(a_no_spurious, i_clk, i_rst_n, !o_valid && o_ready, !o_valid)
endmodule

bind particle_force_euler_step_2d_core pfe_checker u_chk (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_ready(o_ready),
    .o_valid(o_valid), .i_ready(i_ready), .o_out(o_out)
);

@@ sim/particle_force_euler_step_2d_core_test.sv @@
// ----------------------------------------------------------------------------
// particle_force_euler_step_2d_core_test
// Self-checking bench for the 2D particle Euler step core. A queue-fed driver
// sends action beats, a clocked monitor compares every result beat against an
// in-bench predictor of the particle state. Four random phases, each under a
// different register setting, follow a directed opening.
// ----------------------------------------------------------------------------
module particle_force_euler_step_2d_core_test;
    import pfe_pkg::*;

    localparam logic [2:0] ACT_SPARE_LO = 3'd6;
    localparam logic [2:0] ACT_SPARE_HI = 3'd7;
    localparam longint     WORD_MAX     = 64'sd2147483647;
    localparam longint     WORD_MIN     = -64'sd2147483648;
    localparam longint     UNITY        = 64'sd65536;
    localparam int         DRAIN_CYCLES = 300;

    logic        i_clk      = 1'b0;
    logic        i_rst_n    = 1'b0;
    logic        i_valid    = 1'b0;
    logic        o_ready;
    t_in         i_in       = '0;
    logic        o_valid;
    logic        i_ready    = 1'b0;
    t_out        o_out;
    logic        i_cfg_we   = 1'b0;
    logic [2:0]  i_cfg_idx  = '0;
    logic [31:0] i_cfg_data = '0;

    particle_force_euler_step_2d_core DUT (.*);

    // Predicted particle state and register copy.
    longint px, py, vx, vy, ax, ay;
    longint gain_fric, gain_imass, wall_xlo, wall_ylo, wall_xhi, wall_yhi;

    t_in  pending_beats[$];
    t_out expected_states[$];
    int   send_idle_pct;
    int   recv_idle_pct;
    int   mismatches;

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #10_000_000;
        $display("[particle_force_euler_step_2d_core] ERROR");
        $finish;
    end

    function automatic longint clamp_word(input longint v);
        if (v > WORD_MAX) return WORD_MAX;
        if (v < WORD_MIN) return WORD_MIN;
        return v;
    endfunction

    function automatic longint unsigned root64(input longint unsigned n);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'h4000_0000_0000_0000;
        while (b > n) b = b >> 2;
        while (b != 0) begin
            if (n >= r + b) begin
                n = n - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    // Unit component along the difference, scaled by strength and falloff.
    function automatic longint pull_component(input longint d, input longint span,
                                              input longint strength,
                                              input longint pct);
        longint unit_c;
        longint t;
        unit_c = (d * UNITY) / span;
        t      = (unit_c * strength) >>> 16;
        return (t * pct) >>> 16;
    endfunction

    task automatic apply_point(input t_in b, input bit push_away);
        longint dx, dy, reach, span, pct, tx, ty;
        longint unsigned sq;
        dx    = clamp_word(px - longint'(b.point_x));
        dy    = clamp_word(py - longint'(b.point_y));
        reach = b.reach;
        sq    = longint'(dx * dx) + longint'(dy * dy);
        span  = longint'(root64(sq));
        if (reach > 0 && span > reach) return;
        if (span == 0) return;
        pct = (reach > 0) ? UNITY - (span * UNITY) / reach : UNITY;
        tx  = pull_component(dx, span, b.strength, pct);
        ty  = pull_component(dy, span, b.strength, pct);
        if (push_away) begin
            ax = clamp_word(ax + tx);
            ay = clamp_word(ay + ty);
        end else begin
            ax = clamp_word(ax - tx);
            ay = clamp_word(ay - ty);
        end
    endtask

    // Advance the predicted particle by one beat and return the reported state.
    task automatic advance_particle(input t_in b, output t_out r);
        case (b.action)
            ACT_FORCE: begin
                ax = clamp_word(ax + clamp_word((longint'(b.force_x) * gain_imass) >>> 16));
                ay = clamp_word(ay + clamp_word((longint'(b.force_y) * gain_imass) >>> 16));
            end
            ACT_ATTRACT: apply_point(b, 1'b0);
            ACT_REPEL:   apply_point(b, 1'b1);
            ACT_INTEGRATE: begin
                ax = clamp_word(ax - ((vx * gain_fric) >>> 16));
                ay = clamp_word(ay - ((vy * gain_fric) >>> 16));
                vx = clamp_word(vx + ax);
                vy = clamp_word(vy + ay);
                px = clamp_word(px + vx);
                py = clamp_word(py + vy);
                ax = 0;
                ay = 0;
            end
            ACT_BOUNCE: begin
                if (px > wall_xhi) begin px = wall_xhi; vx = clamp_word(-vx); end
                if (px < wall_xlo) begin px = wall_xlo; vx = clamp_word(-vx); end
                if (py > wall_yhi) begin py = wall_yhi; vy = clamp_word(-vy); end
                if (py < wall_ylo) begin py = wall_ylo; vy = clamp_word(-vy); end
            end
            ACT_WRAP: begin
                if (px < wall_xlo) px = wall_xhi;
                if (py < wall_ylo) py = wall_yhi;
                if (px > wall_xhi) px = wall_xlo;
                if (py > wall_yhi) py = wall_ylo;
            end
            default: ;
        endcase
        r.pos_x = px[31:0];
        r.pos_y = py[31:0];
        r.vel_x = vx[31:0];
        r.vel_y = vy[31:0];
    endtask

    // Driver: hold the beat until accepted, then predict and load the next.
    always @(posedge i_clk) begin
        t_out predicted;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else if (!i_valid || o_ready) begin
            if (i_valid) begin
                advance_particle(i_in, predicted);
                expected_states.push_back(predicted);
            end
            if (pending_beats.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                i_valid <= 1'b1;
                i_in    <= pending_beats.pop_front();
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        i_ready <= i_rst_n && ($urandom_range(99) >= recv_idle_pct);
    end

    // Monitor: compare each result beat with the oldest prediction.
    always @(posedge i_clk) begin
        t_out want;
        if (i_rst_n && o_valid && i_ready) begin
            if (expected_states.size() == 0) begin
                $display("%0t: unexpected result beat %h", $time, o_out);
                mismatches++;
            end else begin
                want = expected_states.pop_front();
                if (o_out.pos_x !== want.pos_x) begin
                    $display("%0t: pos_x exp %h got %h", $time, want.pos_x, o_out.pos_x);
                    mismatches++;
                end
                if (o_out.pos_y !== want.pos_y) begin
                    $display("%0t: pos_y exp %h got %h", $time, want.pos_y, o_out.pos_y);
                    mismatches++;
                end
                if (o_out.vel_x !== want.vel_x) begin
                    $display("%0t: vel_x exp %h got %h", $time, want.vel_x, o_out.vel_x);
                    mismatches++;
                end
                if (o_out.vel_y !== want.vel_y) begin
                    $display("%0t: vel_y exp %h got %h", $time, want.vel_y, o_out.vel_y);
                    mismatches++;
                end
            end
        end
    end

    // Block until the driver has sent everything and every result is back.
    // Sample at the falling edge so the clocked blocks have settled.
    task automatic drain;
        @(negedge i_clk);
        while (pending_beats.size() > 0 || i_valid || expected_states.size() > 0)
            @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        case (idx)
            CFG_FRICTION: gain_fric  = longint'(val[16:0]);
            CFG_INV_MASS: gain_imass = longint'(val[30:0]);
            CFG_XMIN:     wall_xlo   = longint'(signed'(val));
            CFG_YMIN:     wall_ylo   = longint'(signed'(val));
            CFG_XMAX:     wall_xhi   = longint'(signed'(val));
            CFG_YMAX:     wall_yhi   = longint'(signed'(val));
            default: ;
        endcase
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic load_regs(input logic [31:0] fric, input logic [31:0] imass,
                             input logic [31:0] xlo, input logic [31:0] ylo,
                             input logic [31:0] xhi, input logic [31:0] yhi);
        write_reg(CFG_FRICTION, fric);
        write_reg(CFG_INV_MASS, imass);
        write_reg(CFG_XMIN, xlo);
        write_reg(CFG_YMIN, ylo);
        write_reg(CFG_XMAX, xhi);
        write_reg(CFG_YMAX, yhi);
    endtask

    function automatic t_in beat_of(input logic [2:0] act, input longint a,
                                    input longint b, input longint pxv,
                                    input longint pyv, input longint rv,
                                    input longint sv);
        t_in v;
        v.action   = act;
        v.force_x  = a[31:0];
        v.force_y  = b[31:0];
        v.point_x  = pxv[31:0];
        v.point_y  = pyv[31:0];
        v.reach    = rv[31:0];
        v.strength = sv[31:0];
        return v;
    endfunction

    // Mostly plausible motion: nearby points, modest forces, regular steps.
    function automatic t_in random_beat;
        t_in          v;
        int           pick;
        logic [223:0] raw_bits;
        v = beat_of(3'($urandom_range(5)),
                    longint'(signed'($urandom())) >>> $urandom_range(31),
                    longint'(signed'($urandom())) >>> $urandom_range(31),
                    px + (longint'(signed'($urandom())) >>> $urandom_range(8, 31)),
                    py + (longint'(signed'($urandom())) >>> $urandom_range(8, 31)),
                    longint'(signed'($urandom())) >>> $urandom_range(31),
                    longint'(signed'($urandom())) >>> $urandom_range(31));
        pick = $urandom_range(99);
        if (pick < 8) begin
            raw_bits = {$urandom(), $urandom(), $urandom(), $urandom(), $urandom(),
                        $urandom(), $urandom()};
            v = raw_bits[$bits(t_in)-1:0];
        end else if (pick < 12 && (v.reach == 0 || v.reach[31])) begin
            v.reach = -v.reach;
        end
        return v;
    endfunction

    task automatic run_phase(input int sidle, input int ridle, input int count);
        send_idle_pct = sidle;
        recv_idle_pct = ridle;
        for (int n = 0; n < count; n++) begin
            pending_beats.push_back(random_beat());
            // Let the sender stall until the pipe is empty now and then.
            if (n % 45 == 44) drain();
        end
        drain();
    endtask

    initial begin
        px = 33554432; py = 25165824; vx = 0; vy = 0; ax = 0; ay = 0;
        gain_fric = 655; gain_imass = 65536;
        wall_xlo = 0; wall_ylo = 0; wall_xhi = 67108864; wall_yhi = 50331648;
        mismatches    = 0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed opening on reset registers: force extremes, every action,
        // spare codes, and the attract/repel corner cases.
        pending_beats.push_back(beat_of(ACT_SPARE_LO, 0, 0, 0, 0, 0, 0));
        pending_beats.push_back(beat_of(ACT_FORCE, WORD_MAX, WORD_MIN, 0, 0, 0, 0));
        pending_beats.push_back(beat_of(ACT_FORCE, WORD_MIN, WORD_MAX, 0, 0, 0, 0));
        pending_beats.push_back(beat_of(ACT_FORCE, -1, 1, 0, 0, 0, 0));
        pending_beats.push_back(beat_of(ACT_INTEGRATE, 0, 0, 0, 0, 0, 0));
        pending_beats.push_back(beat_of(ACT_SPARE_HI, -1, -1, -1, -1, -1, -1));
        drain();
        // Zero distance: point sits on the particle.
        pending_beats.push_back(beat_of(ACT_ATTRACT, 0, 0, px, py, 0, 65536));
        pending_beats.push_back(beat_of(ACT_ATTRACT, 0, 0, px + 655360, py - 327680,
                                        0, 65536 * 10));
        pending_beats.push_back(beat_of(ACT_REPEL, 0, 0, px - 65536, py + 65536,
                                        65536 * 4, WORD_MAX));
        pending_beats.push_back(beat_of(ACT_REPEL, 0, 0, px + 65536 * 100, py,
                                        65536, 65536));          // out of reach
        pending_beats.push_back(beat_of(ACT_ATTRACT, 0, 0, WORD_MIN, WORD_MAX,
                                        WORD_MIN, WORD_MIN));
        pending_beats.push_back(beat_of(ACT_REPEL, 0, 0, WORD_MAX, WORD_MIN,
                                        WORD_MAX, WORD_MAX));
        pending_beats.push_back(beat_of(ACT_INTEGRATE, 0, 0, 0, 0, 0, 0));
        pending_beats.push_back(beat_of(ACT_FORCE, 65536 * 2000, -65536 * 2000, 0, 0, 0, 0));
        pending_beats.push_back(beat_of(ACT_INTEGRATE, 0, 0, 0, 0, 0, 0));
        pending_beats.push_back(beat_of(ACT_BOUNCE, 0, 0, 0, 0, 0, 0));
        pending_beats.push_back(beat_of(ACT_INTEGRATE, 0, 0, 0, 0, 0, 0));
        pending_beats.push_back(beat_of(ACT_WRAP, 0, 0, 0, 0, 0, 0));
        pending_beats.push_back(beat_of(ACT_FORCE, WORD_MIN, WORD_MAX, 0, 0, 0, 0));
        pending_beats.push_back(beat_of(ACT_INTEGRATE, 0, 0, 0, 0, 0, 0));
        pending_beats.push_back(beat_of(ACT_WRAP, 0, 0, 0, 0, 0, 0));
        pending_beats.push_back(beat_of(ACT_BOUNCE, 0, 0, 0, 0, 0, 0));
        drain();

        // Typical registers with some real drag and mass.
        load_regs(32'd6554, 32'd32768, 32'hffc0_0000, 32'h0, 32'h0400_0000, 32'h0300_0000);
        run_phase(23, 67, 130);

        // Extremes: friction above one, heaviest inverse mass, crossed walls.
        load_regs(32'hffff_ffff, 32'hffff_ffff, 32'h7fff_ffff, 32'h0010_0000,
                  32'h8000_0000, 32'hfff0_0000);
        run_phase(67, 23, 130);

        // Opposite extremes: no drag, zero inverse mass, widest walls.
        load_regs(32'h0, 32'h0, 32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff);
        run_phase(0, 0, 60);
        load_regs(32'h0001_0000, 32'h0001_0000, 32'hff00_0000, 32'hff00_0000,
                  32'h0100_0000, 32'h0100_0000);
        run_phase(0, 0, 80);

        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0 && expected_states.size() == 0) begin
            $display("[particle_force_euler_step_2d_core] OK");
        end else begin
            $display("[particle_force_euler_step_2d_core] ERROR");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
+incdir+src
src/pfe_pkg.sv
src/pfe_divsqrt.sv
src/particle_force_euler_step_2d_core.sv
src/pfe_checker.sv
sim/particle_force_euler_step_2d_core_test.sv
